// ===== src/uvr_pkg.sv =====
// uvr_pkg: shared types and constants for the UTF-8 validate/replace block.
// No dependencies; used by every module under src/.
`timescale 1ns / 1ps

package uvr_pkg;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       replaced;
    logic       last;
  } out_item_t;

  // Sequence length implied by a lead byte; SL_BAD means never a valid lead.
  typedef enum logic [2:0] {
    SL_BAD   = 3'd0,
    SL_ONE   = 3'd1,
    SL_TWO   = 3'd2,
    SL_THREE = 3'd3,
    SL_FOUR  = 3'd4
  } seq_len_t;

  // Leads whose second byte has a narrowed range.
  typedef enum logic [2:0] {
    LK_OTHER,
    LK_E0,
    LK_ED,
    LK_F0,
    LK_F4
  } lead_kind_t;

  // Byte plus the classification the back end needs.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
    seq_len_t   len;
    lead_kind_t kind;
    logic       is_cont;   // 80..BF
    logic       ge_a0;
    logic       le_9f;
    logic       ge_90;
    logic       le_8f;
  } cls_item_t;

  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LIM_A0    = 8'hA0;
  localparam logic [7:0] LIM_9F    = 8'h9F;
  localparam logic [7:0] LIM_90    = 8'h90;
  localparam logic [7:0] LIM_8F    = 8'h8F;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;

endpackage

// ===== src/uvr_front.sv =====
// uvr_front: classifies each incoming byte (lead length, special leads,
// continuation sub-ranges). Depends on uvr_pkg.
`timescale 1ns / 1ps

module uvr_front (
  input  uvr_pkg::in_item_t  in_item,
  output uvr_pkg::cls_item_t cls_item
);

  logic [7:0] b;

  assign b = in_item.data_byte;

  always_comb begin
    cls_item               = '0;
    cls_item.data_byte     = b;
    cls_item.end_of_string = in_item.end_of_string;

    priority if (b < uvr_pkg::CONT_LO) begin
      cls_item.len = uvr_pkg::SL_ONE;
    end else if (b >= uvr_pkg::LEAD2_LO && b <= uvr_pkg::LEAD2_HI) begin
      cls_item.len = uvr_pkg::SL_TWO;
    end else if (b >= uvr_pkg::LEAD3_LO && b <= uvr_pkg::LEAD3_HI) begin
      cls_item.len = uvr_pkg::SL_THREE;
    end else if (b >= uvr_pkg::LEAD4_LO && b <= uvr_pkg::LEAD4_HI) begin
      cls_item.len = uvr_pkg::SL_FOUR;
    end else begin
      cls_item.len = uvr_pkg::SL_BAD;
    end

    priority if (b == uvr_pkg::LEAD3_LO) begin
      cls_item.kind = uvr_pkg::LK_E0;
    end else if (b == uvr_pkg::LEAD_ED) begin
      cls_item.kind = uvr_pkg::LK_ED;
    end else if (b == uvr_pkg::LEAD4_LO) begin
      cls_item.kind = uvr_pkg::LK_F0;
    end else if (b == uvr_pkg::LEAD4_HI) begin
      cls_item.kind = uvr_pkg::LK_F4;
    end else begin
      cls_item.kind = uvr_pkg::LK_OTHER;
    end

    cls_item.is_cont = (b >= uvr_pkg::CONT_LO) && (b <= uvr_pkg::CONT_HI);
    cls_item.ge_a0   = (b >= uvr_pkg::LIM_A0);
    cls_item.le_9f   = (b <= uvr_pkg::LIM_9F);
    cls_item.ge_90   = (b >= uvr_pkg::LIM_90);
    cls_item.le_8f   = (b <= uvr_pkg::LIM_8F);
  end

endmodule

// ===== src/uvr_fifo.sv =====
// uvr_fifo: small queue of classified bytes between front and back end.
// Depends on uvr_pkg.
`timescale 1ns / 1ps

module uvr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  uvr_pkg::cls_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output uvr_pkg::cls_item_t rd_data,
  output logic               valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  uvr_pkg::cls_item_t mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == FULL_CNT);
  assign valid   = (cnt_r != '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/uvr_back.sv =====
// uvr_back: holds the undecided sequence window, decides one byte per cycle
// while the output slot is free, and drives the output register. Depends on uvr_pkg.
`timescale 1ns / 1ps

module uvr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  uvr_pkg::cls_item_t q_data,
  output logic               q_take,
  input  logic               pop,
  output logic               empty,
  output uvr_pkg::out_item_t out_item
);

  // Held bytes: at most three stay undecided between cycles.
  uvr_pkg::cls_item_t win_r [3];
  uvr_pkg::cls_item_t win_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] commit_r, commit_nxt;   // bytes at the front already validated
  logic       eos_r, eos_nxt;         // end marker is inside the window
  logic       out_valid_r, out_valid_nxt;
  uvr_pkg::out_item_t out_r, out_nxt;

  uvr_pkg::cls_item_t w [4];
  uvr_pkg::cls_item_t lead;
  logic [2:0] m;
  logic [2:0] need;
  logic       e;
  logic       slot_free;
  logic       lead_ok;
  logic [3:1] cont_ok;
  logic       fail;
  logic       emit;
  logic       rep;
  logic [2:0] m_after;

  assign slot_free = !out_valid_r || pop;
  assign q_take    = q_valid && !eos_r && slot_free;
  assign empty     = !out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    // window = held bytes followed by the queue head when taken
    w[0] = win_r[0];
    w[1] = win_r[1];
    w[2] = win_r[2];
    w[3] = q_data;
    if (q_take) begin
      w[cnt_r] = q_data;
    end
    m    = {1'b0, cnt_r} + {2'b00, q_take};
    e    = eos_r || (q_take && q_data.end_of_string);
    lead = w[0];
    need = lead.len;

    unique case (lead.kind)
      uvr_pkg::LK_E0:    lead_ok = w[1].ge_a0;
      uvr_pkg::LK_ED:    lead_ok = w[1].le_9f;
      uvr_pkg::LK_F0:    lead_ok = w[1].ge_90;
      uvr_pkg::LK_F4:    lead_ok = w[1].le_8f;
      default:           lead_ok = 1'b1;
    endcase
    cont_ok[1] = w[1].is_cont && lead_ok;
    cont_ok[2] = w[2].is_cont;
    cont_ok[3] = w[3].is_cont;

    fail = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if ((3'(i) < m) && (3'(i) < need) && !cont_ok[i]) begin
        fail = 1'b1;
      end
    end

    emit       = 1'b0;
    rep        = 1'b0;
    commit_nxt = commit_r;
    if (slot_free) begin
      priority if (m == 3'd0) begin
        emit = 1'b0;
      end else if (commit_r != 2'd0) begin
        emit       = 1'b1;
        commit_nxt = commit_r - 2'd1;
      end else if (lead.len == uvr_pkg::SL_ONE) begin
        emit = 1'b1;
      end else if (lead.len == uvr_pkg::SL_BAD || fail) begin
        emit = 1'b1;
        rep  = 1'b1;
      end else if (m >= need) begin
        emit       = 1'b1;
        commit_nxt = 2'(need - 3'd1);
      end else if (e) begin
        // sequence cut short by the end marker
        emit = 1'b1;
        rep  = 1'b1;
      end else begin
        emit = 1'b0;
      end
    end

    m_after = emit ? (m - 3'd1) : m;

    if (emit) begin
      win_nxt[0] = w[1];
      win_nxt[1] = w[2];
      win_nxt[2] = w[3];
    end else begin
      win_nxt[0] = w[0];
      win_nxt[1] = w[1];
      win_nxt[2] = w[2];
    end

    if (slot_free) begin
      cnt_nxt = m_after[1:0];
      eos_nxt = e && (m_after != 3'd0);
    end else begin
      cnt_nxt = cnt_r;
      eos_nxt = eos_r;
    end

    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt    = 1'b1;
      out_nxt.out_byte = rep ? uvr_pkg::QMARK : lead.data_byte;
      out_nxt.replaced = rep;
      out_nxt.last     = e && (m == 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      commit_r    <= '0;
      eos_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      commit_r    <= commit_nxt;
      eos_r       <= eos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r[0] <= win_nxt[0];
    win_r[1] <= win_nxt[1];
    win_r[2] <= win_nxt[2];
    out_r    <= out_nxt;
  end

endmodule

// ===== src/utf8_validate_replace.sv =====
// utf8_validate_replace: top level, front classifier -> queue -> back end.
// Depends on uvr_pkg, uvr_front, uvr_fifo, uvr_back.
//
//   channel   handshake      payload
//   input     push / full    in_item  (data_byte, end_of_string)
//   result    pop / empty    out_item (out_byte, replaced, last)
//
// Takes and returns one transaction per cycle while full is low, pop frees the
// result slot and sequences are decided. A byte passes the queue and output
// register before the result ports; a lead byte waits until its sequence is
// decided, up to three more input bytes. When the end marker is taken while
// bytes are held, the back end stops taking until it has flushed them; the
// queue (QUEUE_DEPTH entries) absorbs that, and full rises only once the queue
// has filled. Synchronous active-low reset empties queue, window and output.
`timescale 1ns / 1ps

module utf8_validate_replace #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  uvr_pkg::in_item_t  in_item,
  input  logic               pop,
  output logic               empty,
  output uvr_pkg::out_item_t out_item
);

  uvr_pkg::cls_item_t cls_item;
  uvr_pkg::cls_item_t q_data;
  logic               q_valid;
  logic               q_take;

  uvr_front u_front (
    .in_item  (in_item),
    .cls_item (cls_item)
  );

  uvr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && !full),
    .wr_data (cls_item),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  uvr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_take   (q_take),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
